>>> rtl/core/shmc_pkg.sv
// Shared types and constants for the sliding Hamming match counter.
`default_nettype none

package shmc_pkg;

   // Default sizing
   localparam int QUERY_MAX_DEF  = 32;
   localparam int COUNT_BITS_DEF = 32;

   // Fixed field widths
   localparam int SYM_W   = 8;
   localparam int LEN_W   = 6;
   localparam int CSR_W   = 64;
   localparam int IDX_W   = 3;
   localparam int OUT_W   = 32;
   localparam int QBYTES  = 32;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_QUERY_0   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_QUERY_1   = 3'd1;
   localparam logic [IDX_W-1:0] CSR_QUERY_2   = 3'd2;
   localparam logic [IDX_W-1:0] CSR_QUERY_3   = 3'd3;
   localparam logic [IDX_W-1:0] CSR_QUERY_LEN = 3'd4;
   localparam logic [IDX_W-1:0] CSR_MAX_MISS  = 3'd5;

   // Input word
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } req_payload_type;

   // Result word
   typedef struct packed {
      logic             window_ready;
      logic             match;
      logic [OUT_W-1:0] hit_count;
      logic             done_res;
   } rsp_payload_type;

   // Control carried from the window stage to the score stage
   typedef struct packed {
      logic valid;
      logic ready;
      logic last;
   } stage_type;

endpackage

`default_nettype wire

>>> rtl/core/shmc_csr.sv
// Configuration registers and the lane-aligned query register.
`default_nettype none

module shmc_csr #(
   parameter int QUERY_MAX = shmc_pkg::QUERY_MAX_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [shmc_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [shmc_pkg::CSR_W-1:0]     csr_write_data,
   output logic [shmc_pkg::SYM_W-1:0]          query_aligned [QUERY_MAX],
   output logic [QUERY_MAX-1:0]                lane_mask,
   output logic [shmc_pkg::LEN_W-1:0]          active_len,
   output logic [shmc_pkg::LEN_W-1:0]          max_miss
);

   localparam int QW = shmc_pkg::CSR_W * 4;

   logic [shmc_pkg::CSR_W-1:0] query_ff [4];
   logic [shmc_pkg::LEN_W-1:0] query_len_ff;
   logic [shmc_pkg::LEN_W-1:0] max_miss_ff;
   logic [QW-1:0]              query_flat;
   logic [shmc_pkg::SYM_W-1:0] aligned_in [QUERY_MAX];
   logic [shmc_pkg::SYM_W-1:0] aligned_ff [QUERY_MAX];
   logic [QUERY_MAX-1:0]       mask_in;
   logic [QUERY_MAX-1:0]       mask_ff;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            query_ff[i] <= '0;
         end
         query_len_ff <= shmc_pkg::LEN_W'(1);
         max_miss_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            shmc_pkg::CSR_QUERY_0:   query_ff[0]  <= csr_write_data;
            shmc_pkg::CSR_QUERY_1:   query_ff[1]  <= csr_write_data;
            shmc_pkg::CSR_QUERY_2:   query_ff[2]  <= csr_write_data;
            shmc_pkg::CSR_QUERY_3:   query_ff[3]  <= csr_write_data;
            shmc_pkg::CSR_QUERY_LEN: query_len_ff <= csr_write_data[shmc_pkg::LEN_W-1:0];
            shmc_pkg::CSR_MAX_MISS:  max_miss_ff  <= csr_write_data[shmc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp length to 1..QUERY_MAX
   always_comb begin
      if (query_len_ff == '0) begin
         active_len = shmc_pkg::LEN_W'(1);
      end else if (query_len_ff > shmc_pkg::LEN_W'(QUERY_MAX)) begin
         active_len = shmc_pkg::LEN_W'(QUERY_MAX);
      end else begin
         active_len = query_len_ff;
      end
   end

   assign query_flat = {query_ff[3], query_ff[2], query_ff[1], query_ff[0]};

   // Lane k (byte k items ago) meets query byte len-1-k
   always_comb begin
      logic [shmc_pkg::LEN_W-1:0] j;
      for (int k = 0; k < QUERY_MAX; k++) begin
         j             = active_len - shmc_pkg::LEN_W'(1) - shmc_pkg::LEN_W'(k);
         aligned_in[k] = query_flat[{j[4:0], 3'b000} +: shmc_pkg::SYM_W];
         mask_in[k]    = shmc_pkg::LEN_W'(k) < active_len;
      end
   end

   // Registered; user holds config steady with words in flight, unchecked
   always_ff @(posedge clock) begin
      aligned_ff <= aligned_in;
      mask_ff    <= mask_in;
   end

   assign query_aligned = aligned_ff;
   assign lane_mask     = mask_ff;
   assign max_miss      = max_miss_ff;

endmodule

`default_nettype wire

>>> rtl/core/shmc_window.sv
// Input stage: byte window shift line, fill level and window-full flag.
`default_nettype none

module shmc_window #(
   parameter int QUERY_MAX = shmc_pkg::QUERY_MAX_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         advance,
   input  wire shmc_pkg::req_payload_type    req_payload,
   input  wire logic [shmc_pkg::LEN_W-1:0]   active_len,
   output logic [shmc_pkg::SYM_W-1:0]        window [QUERY_MAX],
   output shmc_pkg::stage_type               stage
);

   localparam int FILL_W = $clog2(QUERY_MAX + 1);

   logic [shmc_pkg::SYM_W-1:0] window_ff [QUERY_MAX];
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_step;
   logic [FILL_W-1:0]          fill_in;
   shmc_pkg::stage_type        stage_ff;
   shmc_pkg::stage_type        stage_in;

   // Shift line: entry 0 is the newest byte
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff[0] <= req_payload.symbol;
         for (int k = 1; k < QUERY_MAX; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
      end
   end

   // Fill level saturates at QUERY_MAX, clears after the last byte
   always_comb begin
      fill_step = (fill_ff < FILL_W'(QUERY_MAX)) ? fill_ff + FILL_W'(1) : fill_ff;
      fill_in   = fill_ff;
      stage_in  = stage_ff;
      if (advance) begin
         stage_in.valid = 1'b0;
      end
      if (accept) begin
         fill_in        = req_payload.last ? '0 : fill_step;
         stage_in.valid = 1'b1;
         stage_in.ready = shmc_pkg::LEN_W'(fill_step) >= active_len;
         stage_in.last  = req_payload.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         stage_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         stage_ff <= stage_in;
      end
   end

   assign window = window_ff;
   assign stage  = stage_ff;

endmodule

`default_nettype wire

>>> rtl/core/shmc_score.sv
// Score stage: byte compares, mismatch popcount, match count and result register.
`default_nettype none

module shmc_score #(
   parameter int QUERY_MAX  = shmc_pkg::QUERY_MAX_DEF,
   parameter int COUNT_BITS = shmc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire shmc_pkg::stage_type          stage,
   input  wire logic [shmc_pkg::SYM_W-1:0]   window [QUERY_MAX],
   input  wire logic [shmc_pkg::SYM_W-1:0]   query_aligned [QUERY_MAX],
   input  wire logic [QUERY_MAX-1:0]         lane_mask,
   input  wire logic [shmc_pkg::LEN_W-1:0]   max_miss,
   input  wire logic                         rsp_stall,
   output logic                              advance,
   output logic                              rsp_valid,
   output shmc_pkg::rsp_payload_type         rsp_payload
);

   logic [shmc_pkg::LEN_W-1:0] miss_count;
   logic                       hit;
   logic [COUNT_BITS-1:0]      count_ff;
   logic [COUNT_BITS-1:0]      count_next;
   logic [63:0]                count_wide;
   logic                       rsp_valid_ff;
   shmc_pkg::rsp_payload_type  rsp_payload_ff;

   // Count differing bytes among the active lanes
   always_comb begin
      miss_count = '0;
      for (int k = 0; k < QUERY_MAX; k++) begin
         miss_count = miss_count +
            shmc_pkg::LEN_W'(lane_mask[k] && (window[k] != query_aligned[k]));
      end
   end

   assign hit        = stage.ready && (miss_count <= max_miss);
   assign count_next = (hit && (count_ff != '1)) ? count_ff + COUNT_BITS'(1) : count_ff;
   assign count_wide = 64'(count_next);

   // Stage word moves on when the result register is empty or being drained
   assign advance = stage.valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         count_ff     <= stage.last ? '0 : count_next;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.window_ready <= stage.ready;
         rsp_payload_ff.match        <= hit;
         rsp_payload_ff.hit_count    <= count_wide[shmc_pkg::OUT_W-1:0];
         rsp_payload_ff.done_res     <= stage.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

>>> rtl/core/sliding_hamming_match_counter_core.sv
// Top level of the sliding-window Hamming match counter.
//
//   Port group  Direction  Handshake          Word
//   req_*       in         req_valid/stall    symbol, last
//   rsp_*       out        rsp_valid/stall    window_ready, match, hit_count, done_res
//   csr_*       in         csr_write_en       index 0..5, 64-bit data
//
// One word is accepted per cycle while req_stall is low. It waits in the window stage
// register; its compare/popcount/count result then enters the result register.
// The QUERY_MAX-lane (32 by default) compare and popcount are combinational.
// Reset is synchronous, active high; it clears the fill level, count and valids.
// req_stall rises only when the window stage holds a word and the result
// register is full and stalled.
`default_nettype none

module sliding_hamming_match_counter_core #(
   parameter int QUERY_MAX  = shmc_pkg::QUERY_MAX_DEF,
   parameter int COUNT_BITS = shmc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire shmc_pkg::req_payload_type    req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output shmc_pkg::rsp_payload_type         rsp_payload,
   input  wire logic                         csr_write_en,
   input  wire logic [shmc_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [shmc_pkg::CSR_W-1:0]   csr_write_data
);

   logic [shmc_pkg::SYM_W-1:0] query_aligned [QUERY_MAX];
   logic [shmc_pkg::SYM_W-1:0] window [QUERY_MAX];
   logic [QUERY_MAX-1:0]       lane_mask;
   logic [shmc_pkg::LEN_W-1:0] active_len;
   logic [shmc_pkg::LEN_W-1:0] max_miss;
   shmc_pkg::stage_type        stage;
   logic                       advance;
   logic                       accept;

   // Input side waits only while the window stage cannot move on
   assign req_stall = stage.valid && !advance;
   assign accept    = req_valid && !req_stall;

   shmc_csr #(
      .QUERY_MAX (QUERY_MAX)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .query_aligned  (query_aligned),
      .lane_mask      (lane_mask),
      .active_len     (active_len),
      .max_miss       (max_miss)
   );

   shmc_window #(
      .QUERY_MAX (QUERY_MAX)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .req_payload (req_payload),
      .active_len  (active_len),
      .window      (window),
      .stage       (stage)
   );

   shmc_score #(
      .QUERY_MAX  (QUERY_MAX),
      .COUNT_BITS (COUNT_BITS)
   ) u_score (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .window        (window),
      .query_aligned (query_aligned),
      .lane_mask     (lane_mask),
      .max_miss      (max_miss),
      .rsp_stall     (rsp_stall),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload)
   );

endmodule

`default_nettype wire
